@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level RTL file of the grid point transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/gprt_pkg.sv @@
// Shared types and constants of the grid point transform.
package gprt_pkg;

   // Fraction bits dropped by each rounding step (Q.22 down to Q.8).
   localparam int FracBits  = 14;
   localparam int RoundBias = 8192;

   // Queue between front and back.
   localparam int FifoDepth   = 4;
   localparam int FifoPtrBits = 2;
   localparam int FifoCntBits = 3;

   // Signed Q24.8 limits.
   localparam logic [31:0] Q24Max = 32'h7FFF_FFFF;
   localparam logic [31:0] Q24Min = 32'h8000_0000;

   // Register reset values.
   localparam logic [15:0] SquareSizeReset = 16'd256;
   localparam logic [15:0] RotWReset       = 16'd16384;

   typedef enum logic [2:0] {
      RegSquareSize = 3'd0,
      RegRotW       = 3'd1,
      RegRotX       = 3'd2,
      RegRotY       = 3'd3,
      RegRotZ       = 3'd4,
      RegShiftX     = 3'd5,
      RegShiftY     = 3'd6,
      RegShiftZ     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [15:0] square_size;
      logic signed [15:0] rot_w;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

@@ hdl/grid_point_rigid_transform.sv @@
// Top level of the grid point transform: config registers, front, queue, back.

// Maps a board corner (column, row) to a 3D point: the flat point
// (col*square_size, row*square_size, 0) is rotated by the quaternion q as
// q*p*conj(q) and the translation is added; each coordinate comes out as
// signed Q24.8, clamped to 32 bits, with rsp_tuser set when any clamp hit.
// q is not normalized, so a non-unit q scales the point by |q|^2. Bits of
// the indices above GRID_INDEX_BITS are ignored. Throughput is one request
// per clock while the result side does not stall; a request passes one
// index register, one queue slot and six arithmetic stages.
// A four-entry queue separates the index front end from the
// multiplier pipe, so a stall on the result side fills the queue before
// req_tready drops. Registers are written through csr_* and must only be
// changed while no request is in flight.

`include "assert_macros.svh"

module grid_point_rigid_transform #(
   parameter  int GRID_INDEX_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,  // grid_col, grid_row
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,  // out_x, out_y, out_z
   output logic [0:0]         rsp_tuser,  // saturated
   // register writes
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   localparam int PointBits = 2 * (GRID_INDEX_BITS + 16);

   gprt_pkg::cfg_type         cfg_ff, cfg_in;
   gprt_pkg::fifo_status_type fifo_status;
   logic                      push, pop;
   logic [PointBits-1:0]      push_data, pop_data;
   logic                      at_limit;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (gprt_pkg::csr_index_type'(csr_index))
            gprt_pkg::RegSquareSize: cfg_in.square_size = csr_wdata[15:0];
            gprt_pkg::RegRotW:       cfg_in.rot_w       = csr_wdata[15:0];
            gprt_pkg::RegRotX:       cfg_in.rot_x       = csr_wdata[15:0];
            gprt_pkg::RegRotY:       cfg_in.rot_y       = csr_wdata[15:0];
            gprt_pkg::RegRotZ:       cfg_in.rot_z       = csr_wdata[15:0];
            gprt_pkg::RegShiftX:     cfg_in.shift_x     = csr_wdata;
            gprt_pkg::RegShiftY:     cfg_in.shift_y     = csr_wdata;
            gprt_pkg::RegShiftZ:     cfg_in.shift_z     = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.square_size <= gprt_pkg::SquareSizeReset;
         cfg_ff.rot_w       <= gprt_pkg::RotWReset;
         cfg_ff.rot_x       <= '0;
         cfg_ff.rot_y       <= '0;
         cfg_ff.rot_z       <= '0;
         cfg_ff.shift_x     <= '0;
         cfg_ff.shift_y     <= '0;
         cfg_ff.shift_z     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: index register and board scaling; the cast keeps the low
   // GRID_INDEX_BITS bits of each 8-bit index field
   gprt_front #(
      .GRID_INDEX_BITS(GRID_INDEX_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .grid_col    (GRID_INDEX_BITS'(req_tdata[7:0])),
      .grid_row    (GRID_INDEX_BITS'(req_tdata[15:8])),
      .square_size (cfg_ff.square_size),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   // queue of flat points
   gprt_fifo #(
      .DATA_BITS(PointBits)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   // back: rotation, translation, clamp, result register
   gprt_back #(
      .GRID_INDEX_BITS(GRID_INDEX_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fifo_status (fifo_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser[0])
   );

   // some coordinate of the current result sits on a rail
   assign at_limit = (rsp_tdata[31:0]  == gprt_pkg::Q24Max) || (rsp_tdata[31:0]  == gprt_pkg::Q24Min)
                  || (rsp_tdata[63:32] == gprt_pkg::Q24Max) || (rsp_tdata[63:32] == gprt_pkg::Q24Min)
                  || (rsp_tdata[95:64] == gprt_pkg::Q24Max) || (rsp_tdata[95:64] == gprt_pkg::Q24Min);

   // a stalled result must freeze the pipe, so nothing leaves the queue
   `ASSERT_CLK(a_no_pop_on_stall, (rsp_tvalid && !rsp_tready) |-> !pop, "pop during stall")
   // the front never writes a full queue, the back never reads an empty one
   `ASSERT_CLK(a_queue_bounds, !(push && fifo_status.full) && !(pop && fifo_status.empty), "queue misuse")
   // a clamp flag means some coordinate sits on a limit
   `ASSERT_CLK(a_sat_at_limit, (rsp_tvalid && rsp_tuser[0]) |-> at_limit, "flag without clamp")
   // no result right after reset
   `ASSERT_CLK_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "result after reset")

endmodule

@@ hdl/gprt_front.sv @@
// Front end: takes grid indices and scales them into flat board points.
module gprt_front #(
   parameter int GRID_INDEX_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [GRID_INDEX_BITS-1:0]     grid_col,
   input  logic [GRID_INDEX_BITS-1:0]     grid_row,
   input  logic [15:0]                    square_size,
   input  gprt_pkg::fifo_status_type      fifo_status,
   output logic                           push,
   output logic [2*(GRID_INDEX_BITS+16)-1:0] push_data
);
   localparam int PxW = GRID_INDEX_BITS + 16;

   logic                       hold_vld_ff, hold_vld_in;
   logic [GRID_INDEX_BITS-1:0] col_ff, row_ff;
   logic [PxW-1:0]             px, py;

   assign req_tready = !hold_vld_ff || !fifo_status.full;
   assign push       = hold_vld_ff && !fifo_status.full;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (req_tvalid && req_tready) begin
         hold_vld_in = 1'b1;
      end else if (push) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         col_ff <= grid_col;
         row_ff <= grid_row;
      end
   end

   // exact unsigned Q.8 board coordinates
   assign px = PxW'(col_ff) * PxW'(square_size);
   assign py = PxW'(row_ff) * PxW'(square_size);

   assign push_data = {py, px};

endmodule

@@ hdl/gprt_fifo.sv @@
// Short queue of flat board points between front and back.
module gprt_fifo #(
   parameter int DATA_BITS = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DATA_BITS-1:0]      push_data,
   input  logic                      pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output gprt_pkg::fifo_status_type status
);
   logic [DATA_BITS-1:0]             mem_ff [gprt_pkg::FifoDepth];
   logic [gprt_pkg::FifoPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gprt_pkg::FifoPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gprt_pkg::FifoCntBits-1:0] count_ff, count_in;

   assign status.full  = (count_ff == gprt_pkg::FifoCntBits'(gprt_pkg::FifoDepth));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/gprt_back.sv @@
// Back end: two Hamilton products, rounding, translation and clamping.
module gprt_back #(
   parameter int GRID_INDEX_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gprt_pkg::cfg_type                 cfg,
   input  gprt_pkg::fifo_status_type         fifo_status,
   input  logic [2*(GRID_INDEX_BITS+16)-1:0] pop_data,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [95:0]                       rsp_tdata,
   output logic                              rsp_tuser
);
   localparam int PxW = GRID_INDEX_BITS + 16;
   localparam int PW  = PxW + 17;               // q * p product
   localparam int S1W = PW + 1;                 // sum of two products
   localparam int AW  = S1W - gprt_pkg::FracBits;
   localparam int QW  = AW + 16;                // a * conj(q) product
   localparam int S4W = QW + 1;
   localparam int S5W = QW + 2;
   localparam int RW  = S5W - gprt_pkg::FracBits;
   localparam int SW  = ((RW > 32) ? RW : 32) + 1;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   logic signed [PxW:0]   px_s, py_s;
   logic signed [PW-1:0]  m_in  [8];
   logic signed [PW-1:0]  m_ff  [8];
   logic signed [S1W-1:0] asum  [4];
   logic signed [S1W-1:0] abias [4];
   logic signed [AW-1:0]  a_in  [4];
   logic signed [AW-1:0]  a_ff  [4];
   logic signed [QW-1:0]  n_in  [12];
   logic signed [QW-1:0]  n_ff  [12];
   logic signed [S4W-1:0] pr_in [6];
   logic signed [S4W-1:0] pr_ff [6];
   logic signed [S5W-1:0] rbias [3];
   logic signed [RW-1:0]  r_in  [3];
   logic signed [RW-1:0]  r_ff  [3];
   logic signed [SW-1:0]  t     [3];
   logic [31:0]           o_in  [3];
   logic [31:0]           o_ff  [3];
   logic [2:0]            ovf;
   logic                  sat_ff;

   // whole pipe moves unless the output register is stalled
   assign en  = !v6_ff || rsp_tready;
   assign pop = en && !fifo_status.empty;

   // stage 1: a = q * (0, px, py, 0), eight products
   always_comb begin
      px_s = signed'({1'b0, pop_data[PxW-1:0]});
      py_s = signed'({1'b0, pop_data[2*PxW-1:PxW]});
      m_in[0] = PW'(cfg.rot_x) * PW'(px_s);
      m_in[1] = PW'(cfg.rot_y) * PW'(py_s);
      m_in[2] = PW'(cfg.rot_w) * PW'(px_s);
      m_in[3] = PW'(cfg.rot_z) * PW'(py_s);
      m_in[4] = PW'(cfg.rot_w) * PW'(py_s);
      m_in[5] = PW'(cfg.rot_z) * PW'(px_s);
      m_in[6] = PW'(cfg.rot_x) * PW'(py_s);
      m_in[7] = PW'(cfg.rot_y) * PW'(px_s);
   end

   // stage 2: combine and round half up to Q.8
   always_comb begin
      asum[0] = -(S1W'(m_ff[0]) + S1W'(m_ff[1]));
      asum[1] = S1W'(m_ff[2]) - S1W'(m_ff[3]);
      asum[2] = S1W'(m_ff[4]) + S1W'(m_ff[5]);
      asum[3] = S1W'(m_ff[6]) - S1W'(m_ff[7]);
      for (int i = 0; i < 4; i++) begin
         abias[i] = asum[i] + S1W'(gprt_pkg::RoundBias);
         a_in[i]  = abias[i][S1W-1:gprt_pkg::FracBits];
      end
   end

   // stage 3: r = a * conj(q), twelve products
   always_comb begin
      n_in[0]  = QW'(a_ff[0]) * QW'(cfg.rot_x);
      n_in[1]  = QW'(a_ff[1]) * QW'(cfg.rot_w);
      n_in[2]  = QW'(a_ff[2]) * QW'(cfg.rot_z);
      n_in[3]  = QW'(a_ff[3]) * QW'(cfg.rot_y);
      n_in[4]  = QW'(a_ff[0]) * QW'(cfg.rot_y);
      n_in[5]  = QW'(a_ff[1]) * QW'(cfg.rot_z);
      n_in[6]  = QW'(a_ff[2]) * QW'(cfg.rot_w);
      n_in[7]  = QW'(a_ff[3]) * QW'(cfg.rot_x);
      n_in[8]  = QW'(a_ff[0]) * QW'(cfg.rot_z);
      n_in[9]  = QW'(a_ff[1]) * QW'(cfg.rot_y);
      n_in[10] = QW'(a_ff[2]) * QW'(cfg.rot_x);
      n_in[11] = QW'(a_ff[3]) * QW'(cfg.rot_w);
   end

   // stage 4: pairwise sums
   always_comb begin
      pr_in[0] = S4W'(n_ff[1])  - S4W'(n_ff[0]);
      pr_in[1] = S4W'(n_ff[3])  - S4W'(n_ff[2]);
      pr_in[2] = S4W'(n_ff[5])  - S4W'(n_ff[4]);
      pr_in[3] = S4W'(n_ff[6])  - S4W'(n_ff[7]);
      pr_in[4] = S4W'(n_ff[10]) - S4W'(n_ff[8]);
      pr_in[5] = S4W'(n_ff[11]) - S4W'(n_ff[9]);
   end

   // stage 5: final sum and rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rbias[i] = S5W'(pr_ff[2*i]) + S5W'(pr_ff[2*i+1])
                  + S5W'(gprt_pkg::RoundBias);
         r_in[i]  = rbias[i][S5W-1:gprt_pkg::FracBits];
      end
   end

   // stage 6: translate and clamp to signed 32 bits
   always_comb begin
      t[0] = SW'(r_ff[0]) + SW'(cfg.shift_x);
      t[1] = SW'(r_ff[1]) + SW'(cfg.shift_y);
      t[2] = SW'(r_ff[2]) + SW'(cfg.shift_z);
      for (int i = 0; i < 3; i++) begin
         ovf[i]  = !((&t[i][SW-1:31]) || !(|t[i][SW-1:31]));
         o_in[i] = t[i][31:0];
         if (ovf[i]) begin
            o_in[i] = t[i][SW-1] ? gprt_pkg::Q24Min : gprt_pkg::Q24Max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= m_in;
         a_ff   <= a_in;
         n_ff   <= n_in;
         pr_ff  <= pr_in;
         r_ff   <= r_in;
         o_ff   <= o_in;
         sat_ff <= |ovf;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {o_ff[2], o_ff[1], o_ff[0]};
   assign rsp_tuser  = sat_ff;

endmodule
